@@ hdl/wpq_pkg.sv @@
// ----------------------------------------------------------------------------
// wpq_pkg
// Shared types, codes and the straight-line test for the waypoint queue.
// ----------------------------------------------------------------------------
package wpq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_SHIFT = 2'd1,
    OP_CLEAR = 2'd2,
    OP_PRUNE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRUNE,
    S_PRUNE_LAST,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } point_t;

  localparam int unsigned POINT_W = 16;

  // point b lies on the vertical or horizontal line through a and c, which differ
  function automatic logic is_straight(input point_t a, input point_t b, input point_t c);
    logic vert;
    logic horz;
    vert = (a.x == b.x) && (c.x == b.x) && (c.y != a.y);
    horz = (a.y == b.y) && (c.y == b.y) && (c.x != a.x);
    return vert || horz;
  endfunction

endpackage

@@ hdl/wpq_mem.sv @@
// ----------------------------------------------------------------------------
// wpq_mem
// Simple dual-port point store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wpq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/waypoint_queue_with_collinear_prune.sv @@
// ----------------------------------------------------------------------------
// waypoint_queue_with_collinear_prune
// Circular FIFO of grid points with push, shift, clear and axis-aligned collinear pruning.
// ----------------------------------------------------------------------------
// Push, shift, clear and short prune go from idle to finish when taken;
//   the result is registered there, and a new request is taken only once
//   finish is done. A held result stalls the next request in finish.
// Prune of n >= 3 points streams the store through the single read port in
//   prune, writes the tail in prune-last, then sets the result in finish.
// Reset clears the head pointer, count and handshake state; store contents are
//   undefined until written and need no clearing pass.
module waypoint_queue_with_collinear_prune
  import wpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_W   = 32 + 2 * CNT_W + 3,
  localparam int unsigned TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,  // in_x, in_y
  input  logic [1:0]         s_tuser,  // opcode
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata   // head_x, head_y, tail_x, tail_y, count,
                                       // space_left, not_empty, status
);

  localparam int unsigned SUM_W = CNT_W + 1;

  fsm_t             state, state_next;
  logic [PTR_W-1:0] head_ptr;
  logic [CNT_W-1:0] count;
  point_t           tail;
  status_t          status;
  logic             shift_ok;
  logic [PTR_W-1:0] rd_slot;
  logic [PTR_W-1:0] w_slot;
  logic [CNT_W-1:0] w_cnt;
  logic [CNT_W-1:0] arr;
  point_t           p_prev;
  point_t           p_cur;

  logic             s_accept;
  opcode_t          op;
  point_t           in_pt;
  logic             is_full;
  logic [SUM_W-1:0] push_sum;
  logic [PTR_W-1:0] push_slot;
  point_t           rd_pt;
  logic             keep_cur;
  logic             more_rd;
  logic             last_arr;
  logic             out_free;

  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [POINT_W-1:0] mem_wdata;
  logic               mem_re;
  logic [PTR_W-1:0]   mem_raddr;
  logic [POINT_W-1:0] mem_rdata;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign op        = opcode_t'(s_tuser);
  assign in_pt     = '{x: s_tdata[7:0], y: s_tdata[15:8]};
  assign is_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign push_sum  = SUM_W'(head_ptr) + SUM_W'(count);
  assign push_slot = (push_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     PTR_W'(push_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(push_sum);
  assign rd_pt     = point_t'(mem_rdata);
  assign keep_cur  = !is_straight(p_prev, p_cur, rd_pt);
  assign more_rd   = (arr + 1'b1) < count;
  assign last_arr  = (arr == count - 1'b1);
  assign out_free  = !m_tvalid || m_tready;

  wpq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (POINT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_accept) begin
          if (op == OP_PRUNE && count >= CNT_W'(3)) begin
            state_next = S_PRUNE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_PRUNE: begin
        if (last_arr) begin
          state_next = S_PRUNE_LAST;
        end
      end
      S_PRUNE_LAST: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = w_slot;
    mem_wdata = p_cur;
    mem_re    = 1'b0;
    mem_raddr = head_ptr;
    unique case (state)
      S_IDLE: begin
        if (s_accept) begin
          unique case (op)
            OP_PUSH: begin
              mem_we    = !is_full;
              mem_waddr = push_slot;
              mem_wdata = in_pt;
            end
            OP_SHIFT: mem_re = (count != '0);
            OP_PRUNE: mem_re = (count >= CNT_W'(3));
            OP_CLEAR: mem_re = 1'b0;
            default:  mem_re = 1'b0;
          endcase
        end
      end
      S_PRUNE: begin
        mem_re    = more_rd;
        mem_raddr = rd_slot;
        mem_we    = (arr >= CNT_W'(2)) && keep_cur;
      end
      S_PRUNE_LAST: begin
        mem_we    = 1'b1;
        mem_wdata = tail;
      end
      S_FINISH: mem_we = 1'b0;
      default:  mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head_ptr <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            unique case (op)
              OP_PUSH: begin
                shift_ok <= 1'b0;
                if (is_full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  count  <= count + 1'b1;
                  tail   <= in_pt;
                end
              end
              OP_SHIFT: begin
                if (count == '0) begin
                  status   <= ST_EMPTY;
                  shift_ok <= 1'b0;
                end else begin
                  status   <= ST_OK;
                  shift_ok <= 1'b1;
                  head_ptr <= wrap_inc(head_ptr);
                  count    <= count - 1'b1;
                end
              end
              OP_CLEAR: begin
                status   <= ST_OK;
                shift_ok <= 1'b0;
                head_ptr <= '0;
                count    <= '0;
              end
              OP_PRUNE: begin
                status   <= ST_OK;
                shift_ok <= 1'b0;
                rd_slot  <= wrap_inc(head_ptr);
                w_slot   <= wrap_inc(head_ptr);
                w_cnt    <= CNT_W'(1);
                arr      <= '0;
              end
              default: begin
                status   <= ST_OK;
                shift_ok <= 1'b0;
              end
            endcase
          end
        end
        S_PRUNE: begin
          if (more_rd) begin
            rd_slot <= wrap_inc(rd_slot);
          end
          if (arr >= CNT_W'(2) && keep_cur) begin
            w_slot <= wrap_inc(w_slot);
            w_cnt  <= w_cnt + 1'b1;
          end
          p_prev <= p_cur;
          p_cur  <= rd_pt;
          arr    <= arr + 1'b1;
        end
        S_PRUNE_LAST: count <= w_cnt + 1'b1;
        S_FINISH: begin
          if (out_free) begin
            m_tdata  <= TDATA_W'({
              status,
              (count != '0),
              CNT_W'(QUEUE_DEPTH) - count,
              count,
              (count != '0) ? tail.y : 8'd0,
              (count != '0) ? tail.x : 8'd0,
              shift_ok ? rd_pt.y : 8'd0,
              shift_ok ? rd_pt.x : 8'd0
            });
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("point count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    s_accept && op == OP_PUSH && !is_full |=> count == $past(count) + 1'b1)
    else $error("push did not add a point");

  a_prune_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == S_PRUNE_LAST |=> count <= $past(count))
    else $error("prune grew the store");

  a_write_behind_read: assert property (@(posedge clk) disable iff (rst)
    state == S_PRUNE && arr >= CNT_W'(2) |-> w_cnt < arr)
    else $error("prune write overtook the read stream");

  a_no_write_in_finish: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH |-> !mem_we)
    else $error("store written while a result is pending");
`endif

endmodule

@@ sim/tb_waypoint_queue_with_collinear_prune.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_waypoint_queue_with_collinear_prune
// Streams push, shift, clear and prune requests into the waypoint queue and
// checks every result against a software copy of the queue. The software copy
// tracks its own store, head and count. Both stream sides idle at random, and
// the result side holds off once for a long time so the queue stalls its input.
// ----------------------------------------------------------------------------
module tb_waypoint_queue_with_collinear_prune;
  import wpq_pkg::*;

  localparam int DEPTH   = 64;
  localparam int TDATA_W = 56;
  localparam int N_ITEMS = 1400;

  // lowest field last: head_x sits in the low byte
  typedef struct packed {
    logic [1:0] status;
    logic       not_empty;
    logic [6:0] space_left;
    logic [6:0] count;
    logic [7:0] tail_y;
    logic [7:0] tail_x;
    logic [7:0] head_y;
    logic [7:0] head_x;
  } report_t;

  class waypoint_predictor;
    point_t  store [DEPTH];
    int      head;
    int      count;
    int      mismatches;
    int      reports_seen;
    report_t expected_reports [$];

    function int slot(int k);
      return (head + k) % DEPTH;
    endfunction

    // b is on the horizontal or vertical line through the distinct points a and c
    function bit on_straight_run(point_t a, point_t b, point_t c);
      return (a.x == b.x && c.x == b.x && c.y != a.y) ||
             (a.y == b.y && c.y == b.y && c.x != a.x);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void take_request(opcode_t op, point_t pt);
      report_t r;
      point_t  prev;
      point_t  cur;
      point_t  nxt;
      int      w;
      r = '0;
      case (op)
        OP_PUSH: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            store[slot(count)] = pt;
            count++;
          end
        end
        OP_SHIFT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.head_x = store[head].x;
            r.head_y = store[head].y;
            head = slot(1);
            count--;
          end
        end
        OP_CLEAR: begin
          count = 0;
          head  = 0;
        end
        default: begin
          // neighbors are the original ones: prev is the previous original point, kept or not
          if (count >= 3) begin
            prev = store[slot(0)];
            w = 1;
            for (int i = 1; i + 1 < count; i++) begin
              cur = store[slot(i)];
              nxt = store[slot(i + 1)];
              if (!on_straight_run(prev, cur, nxt)) begin
                store[slot(w)] = cur;
                w++;
              end
              prev = cur;
            end
            store[slot(w)] = store[slot(count - 1)];
            count = w + 1;
          end
        end
      endcase
      if (count != 0) begin
        r.tail_x = store[slot(count - 1)].x;
        r.tail_y = store[slot(count - 1)].y;
      end
      r.count      = 7'(count);
      r.space_left = 7'(DEPTH - count);
      r.not_empty  = (count != 0);
      expected_reports.push_back(r);
    endfunction

    function void check_report(logic [TDATA_W-1:0] word);
      report_t got;
      report_t want;
      got = word[48:0];
      reports_seen++;
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("unexpected result %h", word));
        return;
      end
      want = expected_reports.pop_front();
      if (got.head_x !== want.head_x || got.head_y !== want.head_y ||
          got.tail_x !== want.tail_x || got.tail_y !== want.tail_y ||
          got.count !== want.count || got.space_left !== want.space_left ||
          got.not_empty !== want.not_empty || got.status !== want.status ||
          word[TDATA_W-1:49] !== '0)
        note_failure($sformatf(
          "#%0d exp head %0d,%0d tail %0d,%0d cnt %0d left %0d ne %0d st %0d | got %h",
          reports_seen, want.head_x, want.head_y, want.tail_x, want.tail_y,
          want.count, want.space_left, want.not_empty, want.status, word));
    endfunction

    function void flush_leftovers();
      while (expected_reports.size() != 0) begin
        void'(expected_reports.pop_front());
        note_failure("expected result never arrived");
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [15:0]        s_tdata;   // in_x, in_y
  logic [1:0]         s_tuser;   // opcode
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;   // head_x, head_y, tail_x, tail_y, count,
                                 // space_left, not_empty, status

  waypoint_predictor queue_model = new();
  int  n_sent;
  bit  calm;

  waypoint_queue_with_collinear_prune #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(opcode_t op, logic [7:0] x, logic [7:0] y);
    int     gap;
    point_t pt;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pt.x = x;
    pt.y = y;
    queue_model.take_request(op, pt);
    n_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic push_random();
    send_request(OP_PUSH, 8'($urandom), 8'($urandom));
  endtask

  // walk along the grid axes with runs of random length, so prune finds corners
  task automatic push_path(int n);
    logic [7:0] cx;
    logic [7:0] cy;
    bit         along_x;
    int         run;
    int         delta;
    cx = 8'($urandom);
    cy = 8'($urandom);
    along_x = 1'($urandom_range(0, 1));
    run = 0;
    for (int i = 0; i < n; i++) begin
      send_request(OP_PUSH, cx, cy);
      if (run == 0) begin
        if ($urandom_range(0, 4) != 0) along_x = !along_x;
        run = $urandom_range(1, 6);
      end
      run--;
      delta = $urandom_range(1, 40);
      if ($urandom_range(0, 1)) delta = -delta;
      if ($urandom_range(0, 9) == 0) delta = 0;
      if ($urandom_range(0, 19) == 0) begin
        cx = 8'($urandom);
        cy = 8'($urandom);
      end else if (along_x) begin
        cx = cx + 8'(delta);
      end else begin
        cy = cy + 8'(delta);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) queue_model.check_report(m_tdata);
  end

  initial begin : result_side
    int stall;
    int free_run;
    bit held_off;
    stall    = 0;
    free_run = 0;
    held_off = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && queue_model.reports_seen >= 150) begin
        held_off = 1;
        stall    = 600;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (free_run > 0) free_run--;
        else if ($urandom_range(0, 9) == 0) free_run = $urandom_range(20, 80);
        else stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int  pick;
    int  room;
    bit  first_pass;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_PUSH;
    n_sent   = 0;
    calm     = 0;
    first_pass = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(OP_SHIFT, 8'd0, 8'd0);
    send_request(OP_PRUNE, 8'd0, 8'd0);
    send_request(OP_PUSH, 8'd0, 8'd0);
    send_request(OP_PUSH, 8'd255, 8'd255);
    send_request(OP_PRUNE, 8'd0, 8'd0);
    send_request(OP_SHIFT, 8'd0, 8'd0);
    send_request(OP_PUSH, 8'd255, 8'd0);
    send_request(OP_PUSH, 8'd255, 8'd7);
    send_request(OP_PUSH, 8'd0, 8'd7);
    send_request(OP_PUSH, 8'd0, 8'd7);
    send_request(OP_PUSH, 8'd0, 8'd200);
    send_request(OP_PUSH, 8'd0, 8'd7);
    send_request(OP_PRUNE, 8'd0, 8'd0);
    send_request(OP_SHIFT, 8'd0, 8'd0);
    send_request(OP_CLEAR, 8'd0, 8'd0);
    send_request(OP_SHIFT, 8'd0, 8'd0);
    send_request(OP_PUSH, 8'd1, 8'd2);
    send_request(OP_PUSH, 8'd3, 8'd4);
    send_request(OP_PUSH, 8'd5, 8'd6);
    send_request(OP_PRUNE, 8'd0, 8'd0);
    send_request(OP_CLEAR, 8'd0, 8'd0);

    while (n_sent < N_ITEMS + 21) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = first_pass ? 60 : $urandom_range(0, 99);
      first_pass = 0;
      if (pick < 55) begin
        if ($urandom_range(0, 1)) send_request(OP_CLEAR, 8'($urandom), 8'($urandom));
        room = DEPTH - queue_model.count;
        if ($urandom_range(0, 9) == 0) push_path(room + $urandom_range(0, 3));
        else push_path($urandom_range(1, (room < 20) ? room + 1 : 20));
        send_request(OP_PRUNE, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 3)) send_request(OP_SHIFT, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) == 0) send_request(OP_PRUNE, 8'($urandom), 8'($urandom));
      end else if (pick < 63) begin
        while (queue_model.count < DEPTH) push_random();
        repeat ($urandom_range(1, 3)) push_random();
        if ($urandom_range(0, 1)) send_request(OP_PRUNE, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 8)) send_request(OP_SHIFT, 8'($urandom), 8'($urandom));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 10)) send_request(OP_SHIFT, 8'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8))
          send_request(opcode_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (queue_model.expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    queue_model.flush_leftovers();
    if (queue_model.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
